>>> sv/tba_pkg.sv
package tba_pkg;

    localparam int ARENA_BYTES       = 65536;
    localparam int MAX_BLOCKS        = 32;
    localparam int HEADER_BYTES      = 24;
    localparam int MIN_REMAINDER     = 64;
    localparam int SLOT_W            = $clog2(MAX_BLOCKS);
    localparam int START_W           = 16;
    localparam int BYTES_W           = 17;
    localparam int SIZE_W            = BYTES_W + 1;
    localparam int TAG_W             = 8;
    localparam int OWNER_W           = 16;
    localparam int STEP_W            = 8;
    localparam int WALK_LIMIT        = 4 * MAX_BLOCKS;
    localparam int RANGE_LIMIT       = 2 * MAX_BLOCKS;
    localparam int SENTINEL_TAG      = 1;
    localparam int RESET_PURGE_LEVEL = 100;

    localparam logic KIND_OWNER = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    typedef enum logic [1:0] {
        USE_FREE     = 2'd0,
        USE_PLAIN    = 2'd1,
        USE_OWNED    = 2'd2,
        USE_SENTINEL = 2'd3
    } use_t;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_RANGE = 2'd2,
        OP_RETAG = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_MEMORY = 3'd1,
        ST_NO_OWNER  = 3'd2,
        ST_NOT_ALLOC = 3'd3,
        ST_NO_SLOT   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_A_INIT,
        CMD_A_START,
        CMD_A_STEP,
        CMD_A_BASE,
        CMD_A_ROVE,
        CMD_A_COMMIT,
        CMD_SCAN,
        CMD_HIT,
        CMD_TAG,
        CMD_RL0,
        CMD_RL1,
        CMD_RL2,
        CMD_RG_STEP,
        CMD_RG_NEXT
    } cmd_t;

    typedef struct packed {
        cmd_t    cmd;
        logic    emit;
        logic    emit_kind;
        status_t emit_status;
        logic    emit_offset;
    } ctl_t;

    typedef struct packed {
        op_t  op;
        logic own_err;
        logic walk_fail;
        logic r_free;
        logic r_purge;
        logic base_fit;
        logic need_split;
        logic slot_avail;
        logic scan_hit;
        logic scan_end;
        logic rel_owned;
        logic tag_bad;
        logic rg_more;
        logic rg_hit;
        logic out_free;
    } sts_t;

endpackage

>>> sv/tba_datapath.sv
module tba_datapath
    import tba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_t                ctl,
    output sts_t                sts,
    input  logic                cfg_wen,
    input  logic [TAG_W-1:0]    cfg_wdata,
    input  op_t                 in_op,
    input  logic [BYTES_W-1:0]  in_request_bytes,
    input  logic [TAG_W-1:0]    in_tag,
    input  logic                in_has_owner,
    input  logic [OWNER_W-1:0]  in_owner_id,
    input  logic [START_W-1:0]  in_payload_offset,
    input  logic [TAG_W-1:0]    in_low_tag,
    input  logic [TAG_W-1:0]    in_upper_tag,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_kind,
    output logic [2:0]          out_status,
    output logic [START_W-1:0]  out_result_offset,
    output logic [OWNER_W-1:0]  out_cleared_owner,
    output logic                out_last
);

    logic [START_W-1:0] start_reg [MAX_BLOCKS];
    logic [BYTES_W-1:0] bytes_reg [MAX_BLOCKS];
    logic [SLOT_W-1:0]  next_reg  [MAX_BLOCKS];
    logic [SLOT_W-1:0]  prev_reg  [MAX_BLOCKS];
    logic [TAG_W-1:0]   tag_reg   [MAX_BLOCKS];
    logic [OWNER_W-1:0] owner_reg [MAX_BLOCKS];
    use_t               use_reg   [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] taken_reg;
    logic [SLOT_W-1:0]  rover_reg;
    logic [TAG_W-1:0]   level_reg;

    op_t                op_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [TAG_W-1:0]   rtag_reg;
    logic               rown_reg;
    logic [OWNER_W-1:0] rowner_reg;
    logic [START_W-1:0] roff_reg;
    logic [TAG_W-1:0]   lo_reg;
    logic [TAG_W-1:0]   hi_reg;

    logic [SLOT_W-1:0]  base_reg;
    logic [SLOT_W-1:0]  r_reg;
    logic [SLOT_W-1:0]  walk_start_reg;
    logic [SLOT_W-1:0]  rel_reg;
    logic [SLOT_W-1:0]  scan_reg;
    logic [STEP_W-1:0]  steps_reg;

    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [2:0]         out_status_reg;
    logic [START_W-1:0] out_offset_reg;
    logic [OWNER_W-1:0] out_owner_reg;

    logic [SIZE_W-1:0]  rounded;
    logic [SIZE_W-1:0]  extra;
    logic [SLOT_W-1:0]  free_slot;
    logic               free_found;
    logic [SLOT_W-1:0]  init_base;
    logic [SLOT_W-1:0]  p_slot;
    logic [SLOT_W-1:0]  n_slot;
    logic [SIZE_W-1:0]  split_start;

    // one extra bit so the largest requests round up without wrapping
    assign rounded     = ({1'b0, in_request_bytes} + SIZE_W'(3)) & ~SIZE_W'(3);
    assign extra       = {1'b0, bytes_reg[base_reg]} - size_reg;
    assign init_base   = (use_reg[prev_reg[rover_reg]] == USE_FREE) ?
                         prev_reg[rover_reg] : rover_reg;
    assign p_slot      = prev_reg[rel_reg];
    assign n_slot      = next_reg[rel_reg];
    assign split_start = {2'b00, start_reg[base_reg]} + size_reg;

    // lowest untaken slot above the sentinel
    always_comb
    begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int s = MAX_BLOCKS - 1; s >= 1; s--)
        begin
            if (!taken_reg[s])
            begin
                free_slot  = SLOT_W'(s);
                free_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        sts.op         = op_reg;
        sts.own_err    = !rown_reg && (rtag_reg >= level_reg);
        sts.walk_fail  = (r_reg == walk_start_reg) || (steps_reg >= STEP_W'(WALK_LIMIT));
        sts.r_free     = use_reg[r_reg] == USE_FREE;
        sts.r_purge    = (use_reg[r_reg] != USE_SENTINEL) && (tag_reg[r_reg] >= level_reg);
        sts.base_fit   = (use_reg[base_reg] == USE_FREE) &&
                         ({1'b0, bytes_reg[base_reg]} >= size_reg);
        sts.need_split = extra > SIZE_W'(MIN_REMAINDER);
        sts.slot_avail = free_found;
        sts.scan_hit   = taken_reg[scan_reg] &&
                         (use_reg[scan_reg] == USE_PLAIN || use_reg[scan_reg] == USE_OWNED) &&
                         ((start_reg[scan_reg] + START_W'(HEADER_BYTES)) == roff_reg);
        sts.scan_end   = scan_reg == SLOT_W'(MAX_BLOCKS - 1);
        sts.rel_owned  = use_reg[rel_reg] == USE_OWNED;
        sts.tag_bad    = (rtag_reg >= level_reg) && (use_reg[rel_reg] != USE_OWNED);
        sts.rg_more    = (base_reg != '0) && (steps_reg < STEP_W'(RANGE_LIMIT));
        sts.rg_hit     = (use_reg[base_reg] == USE_PLAIN || use_reg[base_reg] == USE_OWNED) &&
                         (tag_reg[base_reg] >= lo_reg) && (tag_reg[base_reg] <= hi_reg);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BLOCKS; i++)
            begin
                start_reg[i] <= '0;
                owner_reg[i] <= '0;
                if (i == 0)
                begin
                    bytes_reg[i] <= '0;
                    next_reg[i]  <= SLOT_W'(1);
                    prev_reg[i]  <= SLOT_W'(1);
                    tag_reg[i]   <= TAG_W'(SENTINEL_TAG);
                    use_reg[i]   <= USE_SENTINEL;
                end
                else
                begin
                    bytes_reg[i] <= (i == 1) ? BYTES_W'(ARENA_BYTES) : '0;
                    next_reg[i]  <= '0;
                    prev_reg[i]  <= '0;
                    tag_reg[i]   <= '0;
                    use_reg[i]   <= USE_FREE;
                end
            end
            taken_reg     <= MAX_BLOCKS'(3);
            rover_reg     <= SLOT_W'(1);
            level_reg     <= TAG_W'(RESET_PURGE_LEVEL);
            out_valid_reg <= 1'b0;
            op_reg        <= OP_ALLOC;
            steps_reg     <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                level_reg <= cfg_wdata;
            end

            if (ctl.emit)
            begin
                out_valid_reg  <= 1'b1;
                out_kind_reg   <= ctl.emit_kind;
                out_status_reg <= ctl.emit_status;
                out_offset_reg <= ctl.emit_offset ?
                                  start_reg[base_reg] + START_W'(HEADER_BYTES) : '0;
                out_owner_reg  <= (ctl.emit_kind == KIND_OWNER) ? owner_reg[rel_reg] : '0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (ctl.cmd)
                CMD_LOAD:
                begin
                    op_reg     <= in_op;
                    size_reg   <= rounded + SIZE_W'(HEADER_BYTES);
                    rtag_reg   <= in_tag;
                    rown_reg   <= in_has_owner;
                    rowner_reg <= in_owner_id;
                    roff_reg   <= in_payload_offset;
                    lo_reg     <= in_low_tag;
                    hi_reg     <= in_upper_tag;
                    scan_reg   <= SLOT_W'(1);
                    steps_reg  <= '0;
                    base_reg   <= next_reg[0];
                end
                CMD_A_INIT:
                begin
                    base_reg <= init_base;
                    r_reg    <= init_base;
                end
                CMD_A_START:
                begin
                    walk_start_reg <= prev_reg[base_reg];
                end
                CMD_A_STEP:
                begin
                    steps_reg <= steps_reg + STEP_W'(1);
                    if (use_reg[r_reg] == USE_FREE)
                    begin
                        r_reg <= next_reg[r_reg];
                    end
                    else if (!sts.r_purge)
                    begin
                        base_reg <= next_reg[r_reg];
                        r_reg    <= next_reg[r_reg];
                    end
                    else
                    begin
                        base_reg <= prev_reg[base_reg];
                        rel_reg  <= r_reg;
                    end
                end
                CMD_A_BASE:
                begin
                    base_reg <= next_reg[base_reg];
                end
                CMD_A_ROVE:
                begin
                    r_reg <= next_reg[base_reg];
                end
                CMD_A_COMMIT:
                begin
                    if (sts.need_split)
                    begin
                        taken_reg[free_slot]           <= 1'b1;
                        start_reg[free_slot]           <= split_start[START_W-1:0];
                        bytes_reg[free_slot]           <= extra[BYTES_W-1:0];
                        use_reg[free_slot]             <= USE_FREE;
                        tag_reg[free_slot]             <= '0;
                        owner_reg[free_slot]           <= '0;
                        prev_reg[free_slot]            <= base_reg;
                        next_reg[free_slot]            <= next_reg[base_reg];
                        prev_reg[next_reg[base_reg]]   <= free_slot;
                        next_reg[base_reg]             <= free_slot;
                        bytes_reg[base_reg]            <= size_reg[BYTES_W-1:0];
                        rover_reg                      <= free_slot;
                    end
                    else
                    begin
                        rover_reg <= next_reg[base_reg];
                    end
                    use_reg[base_reg]   <= rown_reg ? USE_OWNED : USE_PLAIN;
                    owner_reg[base_reg] <= rown_reg ? rowner_reg : '0;
                    tag_reg[base_reg]   <= rtag_reg;
                end
                CMD_SCAN:
                begin
                    scan_reg <= scan_reg + SLOT_W'(1);
                end
                CMD_HIT:
                begin
                    rel_reg <= scan_reg;
                end
                CMD_TAG:
                begin
                    tag_reg[rel_reg] <= rtag_reg;
                end
                CMD_RL0:
                begin
                    use_reg[rel_reg]   <= USE_FREE;
                    tag_reg[rel_reg]   <= '0;
                    owner_reg[rel_reg] <= '0;
                end
                CMD_RL1:
                begin
                    // merge into the lower neighbor
                    if (use_reg[p_slot] == USE_FREE)
                    begin
                        bytes_reg[p_slot]        <= bytes_reg[p_slot] + bytes_reg[rel_reg];
                        next_reg[p_slot]         <= n_slot;
                        prev_reg[n_slot]         <= p_slot;
                        taken_reg[rel_reg]       <= 1'b0;
                        rel_reg                  <= p_slot;
                        if (rover_reg == rel_reg)
                        begin
                            rover_reg <= p_slot;
                        end
                    end
                end
                CMD_RL2:
                begin
                    // absorb the upper neighbor
                    if (use_reg[n_slot] == USE_FREE && n_slot != rel_reg)
                    begin
                        bytes_reg[rel_reg]         <= bytes_reg[rel_reg] + bytes_reg[n_slot];
                        next_reg[rel_reg]          <= next_reg[n_slot];
                        prev_reg[next_reg[n_slot]] <= rel_reg;
                        taken_reg[n_slot]          <= 1'b0;
                        if (rover_reg == n_slot)
                        begin
                            rover_reg <= rel_reg;
                        end
                    end
                end
                CMD_RG_STEP:
                begin
                    steps_reg <= steps_reg + STEP_W'(1);
                    if (sts.rg_hit)
                    begin
                        rel_reg <= base_reg;
                    end
                    else
                    begin
                        base_reg <= next_reg[base_reg];
                    end
                end
                CMD_RG_NEXT:
                begin
                    base_reg <= next_reg[rel_reg];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_kind          = out_kind_reg;
    assign out_status        = out_status_reg;
    assign out_result_offset = out_offset_reg;
    assign out_cleared_owner = out_owner_reg;
    assign out_last          = out_kind_reg;

endmodule

>>> sv/tba_controller.sv
module tba_controller
    import tba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  op_t  in_op,
    output logic in_ready,
    input  sts_t sts,
    output ctl_t ctl
);

    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_A_CHK   = 17'h00002,
        S_A_START = 17'h00004,
        S_A_STEP  = 17'h00008,
        S_A_CHECK = 17'h00010,
        S_A_SPLIT = 17'h00020,
        S_A_DONE  = 17'h00040,
        S_A_BASE  = 17'h00080,
        S_A_ROVE  = 17'h00100,
        S_FIND    = 17'h00200,
        S_TAG     = 17'h00400,
        S_RL0     = 17'h00800,
        S_RL1     = 17'h01000,
        S_RL2     = 17'h02000,
        S_F_DONE  = 17'h04000,
        S_RG_STEP = 17'h08000,
        S_RG_NEXT = 17'h10000
    } state_t;

    typedef enum logic [1:0] {
        RET_ALLOC,
        RET_FREE,
        RET_RANGE
    } ret_t;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        ctl.cmd         = CMD_NONE;
        ctl.emit        = 1'b0;
        ctl.emit_kind   = KIND_DONE;
        ctl.emit_status = ST_OK;
        ctl.emit_offset = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.cmd = CMD_LOAD;
                    case (in_op)
                        OP_ALLOC: state_next = S_A_CHK;
                        OP_RANGE: state_next = S_RG_STEP;
                        default:  state_next = S_FIND;
                    endcase
                end
            end
            S_A_CHK:
            begin
                if (sts.own_err)
                begin
                    if (sts.out_free)
                    begin
                        ctl.emit        = 1'b1;
                        ctl.emit_status = ST_NO_OWNER;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    ctl.cmd    = CMD_A_INIT;
                    state_next = S_A_START;
                end
            end
            S_A_START:
            begin
                ctl.cmd    = CMD_A_START;
                state_next = S_A_STEP;
            end
            S_A_STEP:
            begin
                if (sts.walk_fail)
                begin
                    if (sts.out_free)
                    begin
                        ctl.emit        = 1'b1;
                        ctl.emit_status = ST_NO_MEMORY;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    ctl.cmd = CMD_A_STEP;
                    if (!sts.r_free && sts.r_purge)
                    begin
                        ret_next   = RET_ALLOC;
                        state_next = S_RL0;
                    end
                    else
                    begin
                        state_next = S_A_CHECK;
                    end
                end
            end
            S_A_CHECK:
            begin
                state_next = sts.base_fit ? S_A_SPLIT : S_A_STEP;
            end
            S_A_SPLIT:
            begin
                if (sts.need_split && !sts.slot_avail)
                begin
                    if (sts.out_free)
                    begin
                        ctl.emit        = 1'b1;
                        ctl.emit_status = ST_NO_SLOT;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    ctl.cmd    = CMD_A_COMMIT;
                    state_next = S_A_DONE;
                end
            end
            S_A_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.emit        = 1'b1;
                    ctl.emit_offset = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_A_BASE:
            begin
                ctl.cmd    = CMD_A_BASE;
                state_next = S_A_ROVE;
            end
            S_A_ROVE:
            begin
                ctl.cmd    = CMD_A_ROVE;
                state_next = S_A_CHECK;
            end
            S_FIND:
            begin
                if (sts.scan_hit)
                begin
                    ctl.cmd = CMD_HIT;
                    if (sts.op == OP_FREE)
                    begin
                        ret_next   = RET_FREE;
                        state_next = S_RL0;
                    end
                    else
                    begin
                        state_next = S_TAG;
                    end
                end
                else if (sts.scan_end)
                begin
                    if (sts.out_free)
                    begin
                        ctl.emit        = 1'b1;
                        ctl.emit_status = ST_NOT_ALLOC;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    ctl.cmd = CMD_SCAN;
                end
            end
            S_TAG:
            begin
                if (sts.out_free)
                begin
                    ctl.emit        = 1'b1;
                    ctl.emit_status = sts.tag_bad ? ST_NO_OWNER : ST_OK;
                    ctl.cmd         = sts.tag_bad ? CMD_NONE : CMD_TAG;
                    state_next      = S_IDLE;
                end
            end
            S_RL0:
            begin
                if (!sts.rel_owned || sts.out_free)
                begin
                    ctl.cmd       = CMD_RL0;
                    ctl.emit      = sts.rel_owned;
                    ctl.emit_kind = KIND_OWNER;
                    state_next    = S_RL1;
                end
            end
            S_RL1:
            begin
                ctl.cmd    = CMD_RL1;
                state_next = S_RL2;
            end
            S_RL2:
            begin
                ctl.cmd = CMD_RL2;
                case (ret_reg)
                    RET_ALLOC: state_next = S_A_BASE;
                    RET_FREE:  state_next = S_F_DONE;
                    default:   state_next = S_RG_NEXT;
                endcase
            end
            S_F_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RG_STEP:
            begin
                if (!sts.rg_more)
                begin
                    if (sts.out_free)
                    begin
                        ctl.emit   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ctl.cmd = CMD_RG_STEP;
                    if (sts.rg_hit)
                    begin
                        ret_next   = RET_RANGE;
                        state_next = S_RL0;
                    end
                end
            end
            S_RG_NEXT:
            begin
                ctl.cmd    = CMD_RG_NEXT;
                state_next = S_RG_STEP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= RET_ALLOC;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

>>> sv/tagged_block_allocator_top.sv
// Next-fit coalescing arena allocator with purge tags. The arena is an
// address-ordered ring of up to 32 blocks kept in a slot table with a
// sentinel in slot zero and a rover. One request is taken at a time; each
// request answers with zero or more owner-cleared beats (tuser 0) and ends
// with one completion beat (tuser 1, tlast 1). The output beat sits in a
// register, so a request keeps working until it has a second beat to send.
// Output stalls aside, an allocate walks the ring from the rover (walk capped
// at 128 steps) and releases each purged block that it meets; a free or a tag
// change scans the slot table one slot a cycle (up to 31 slots), and a free
// then releases the block found; a tag-range free visits the blocks in ring
// order and releases each one in range. purge_level_tag is written through
// cfg_wen/cfg_wdata; the user must write it only while idle, as the block
// itself does not enforce that.
module tagged_block_allocator_top
    import tba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata,      // purge_level_tag
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // request_bytes[16:0], tag[24:17], has_owner[25], owner_id[41:26],
    // payload_offset[57:42], low_tag[65:58], upper_tag[73:66], zero fill
    input  logic [79:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], result_offset[18:3], cleared_owner[34:19], zero fill
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

    ctl_t               ctl;
    sts_t               sts;
    logic [2:0]         status;
    logic [START_W-1:0] result_offset;
    logic [OWNER_W-1:0] cleared_owner;

    // sequence each request step by step
    tba_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (op_t'(s_axis_tuser)),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // hold the slot table, walk pointers and output beat
    tba_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .sts               (sts),
        .cfg_wen           (cfg_wen),
        .cfg_wdata         (cfg_wdata),
        .in_op             (op_t'(s_axis_tuser)),
        .in_request_bytes  (s_axis_tdata[16:0]),
        .in_tag            (s_axis_tdata[24:17]),
        .in_has_owner      (s_axis_tdata[25]),
        .in_owner_id       (s_axis_tdata[41:26]),
        .in_payload_offset (s_axis_tdata[57:42]),
        .in_low_tag        (s_axis_tdata[65:58]),
        .in_upper_tag      (s_axis_tdata[73:66]),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_kind          (m_axis_tuser),
        .out_status        (status),
        .out_result_offset (result_offset),
        .out_cleared_owner (cleared_owner),
        .out_last          (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, cleared_owner, result_offset, status};

endmodule

>>> sv/tba_checker.sv
module tba_checker
    import tba_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // only the completion closes a request
    a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
        else $error("tlast disagrees with beat kind");

    // owner-cleared beats carry no status and no offset
    a_owner_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[18:0] == 19'd0))
        else $error("owner beat with status or offset");

    // completions never name an owner; failures give no offset
    a_done_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        ((m_axis_tdata[34:19] == 16'd0) &&
         ((m_axis_tdata[2:0] == 3'd0) || (m_axis_tdata[18:3] == 16'd0))))
        else $error("bad completion beat");

    // a stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output beat changed under stall");

endmodule

bind tagged_block_allocator_top tba_checker u_tba_checker (.*);

>>> tb/sv/tagged_block_allocator_top_tb.sv
`timescale 1ns / 1ps

module tagged_block_allocator_top_tb;
    import tba_pkg::*;

    localparam int IDLE_LIMIT = 20000;   // cycles with no beat on either side
    localparam int DRAIN_WAIT = 600;     // extra wait before a purge level write

    typedef struct {
        logic        kind;
        status_t     status;
        logic [15:0] offset;
        logic [15:0] owner;
        logic        last;
    } beat_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [7:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    tagged_block_allocator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow copy of the slot table, kept in step with every accepted request.
    int unsigned blk_start [MAX_BLOCKS];
    int unsigned blk_bytes [MAX_BLOCKS];
    int unsigned blk_next  [MAX_BLOCKS];
    int unsigned blk_prev  [MAX_BLOCKS];
    int unsigned blk_tag   [MAX_BLOCKS];
    int unsigned blk_owner [MAX_BLOCKS];
    use_t        blk_use   [MAX_BLOCKS];
    bit          blk_taken [MAX_BLOCKS];
    int unsigned rover;
    int unsigned purge_level;

    beat_t pending_beats[$];
    int    beats_this_req;
    int    errors;
    int    req_accepted;
    int    idle_cycles;
    bit    hold_off_req;   // ask the receiver for one long hold-off
    bit    calm;           // no idling on either side while set

    // ---------------------------------------------------------------
    // Allocator shadow model
    // ---------------------------------------------------------------
    function automatic void push_beat(logic kind, status_t st, int unsigned off,
                                      int unsigned own, int unsigned last);
        beat_t b;
        if (beats_this_req >= 33)
            return;
        b.kind   = kind;
        b.status = st;
        b.offset = off[15:0];
        b.owner  = own[15:0];
        b.last   = last[0];
        pending_beats.push_back(b);
        beats_this_req++;
    endfunction

    function automatic void shadow_reset();
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            blk_start[i] = 0;
            blk_bytes[i] = 0;
            blk_next[i]  = 0;
            blk_prev[i]  = 0;
            blk_tag[i]   = 0;
            blk_owner[i] = 0;
            blk_use[i]   = USE_FREE;
            blk_taken[i] = 0;
        end
        blk_tag[0]   = SENTINEL_TAG;
        blk_use[0]   = USE_SENTINEL;
        blk_next[0]  = 1;
        blk_prev[0]  = 1;
        blk_taken[0] = 1;
        blk_bytes[1] = ARENA_BYTES;
        blk_taken[1] = 1;
        rover        = 1;
        purge_level  = RESET_PURGE_LEVEL;
    endfunction

    // Release a block, merge with free neighbors, return the surviving slot.
    function automatic int unsigned release_slot(int unsigned s);
        int unsigned p;
        int unsigned n;
        if (blk_use[s] == USE_OWNED)
            push_beat(KIND_OWNER, ST_OK, 0, blk_owner[s], 0);
        blk_use[s]   = USE_FREE;
        blk_tag[s]   = 0;
        blk_owner[s] = 0;
        p = blk_prev[s];
        if (blk_use[p] == USE_FREE)
        begin
            blk_bytes[p] += blk_bytes[s];
            blk_next[p] = blk_next[s];
            blk_prev[blk_next[s]] = p;
            if (rover == s)
                rover = p;
            blk_taken[s] = 0;
            s = p;
        end
        n = blk_next[s];
        if (blk_use[n] == USE_FREE && n != s)
        begin
            blk_bytes[s] += blk_bytes[n];
            blk_next[s] = blk_next[n];
            blk_prev[blk_next[n]] = s;
            if (rover == n)
                rover = s;
            blk_taken[n] = 0;
        end
        return s;
    endfunction

    function automatic int unsigned lookup_offset(int unsigned off);
        for (int unsigned s = 1; s < MAX_BLOCKS; s++)
            if (blk_taken[s] && (blk_use[s] == USE_PLAIN || blk_use[s] == USE_OWNED) &&
                ((blk_start[s] + HEADER_BYTES) & 16'hFFFF) == off)
                return s;
        return 0;
    endfunction

    function automatic bit purgeable(int unsigned s);
        return blk_use[s] != USE_SENTINEL && blk_tag[s] >= purge_level;
    endfunction

    function automatic void predict_alloc(int unsigned req, int unsigned tag, bit has_own,
                                          int unsigned own);
        int unsigned sz;
        int unsigned base;
        int unsigned r;
        int unsigned stop_at;
        int unsigned steps;
        int unsigned extra;
        int unsigned ns;
        if (!has_own && tag >= purge_level)
        begin
            push_beat(KIND_DONE, ST_NO_OWNER, 0, 0, 1);
            return;
        end
        sz = ((req + 3) & ~32'd3) + HEADER_BYTES;
        base = rover;
        if (blk_use[blk_prev[base]] == USE_FREE)
            base = blk_prev[base];
        r = base;
        stop_at = blk_prev[base];
        steps = 0;
        do
        begin
            steps++;
            if (r == stop_at || steps > WALK_LIMIT)
            begin
                push_beat(KIND_DONE, ST_NO_MEMORY, 0, 0, 1);
                return;
            end
            if (blk_use[r] != USE_FREE)
            begin
                if (!purgeable(r))
                begin
                    base = blk_next[r];
                    r = base;
                end
                else
                begin
                    base = blk_prev[base];
                    void'(release_slot(r));
                    base = blk_next[base];
                    r = blk_next[base];
                end
            end
            else
                r = blk_next[r];
        end
        while (blk_use[base] != USE_FREE || blk_bytes[base] < sz);

        extra = blk_bytes[base] - sz;
        if (extra > MIN_REMAINDER)
        begin
            ns = 0;
            for (int unsigned s = 1; s < MAX_BLOCKS; s++)
                if (!blk_taken[s] && ns == 0)
                    ns = s;
            if (ns == 0)
            begin
                push_beat(KIND_DONE, ST_NO_SLOT, 0, 0, 1);
                return;
            end
            blk_taken[ns] = 1;
            blk_start[ns] = blk_start[base] + sz;
            blk_bytes[ns] = extra;
            blk_use[ns]   = USE_FREE;
            blk_tag[ns]   = 0;
            blk_owner[ns] = 0;
            blk_prev[ns]  = base;
            blk_next[ns]  = blk_next[base];
            blk_prev[blk_next[base]] = ns;
            blk_next[base] = ns;
            blk_bytes[base] = sz;
        end
        blk_use[base]   = has_own ? USE_OWNED : USE_PLAIN;
        blk_owner[base] = has_own ? own : 0;
        blk_tag[base]   = tag;
        rover = blk_next[base];
        push_beat(KIND_DONE, ST_OK, blk_start[base] + HEADER_BYTES, 0, 1);
    endfunction

    function automatic void predict_request(op_t op, logic [79:0] d);
        int unsigned s;
        int unsigned b;
        int unsigned steps;
        int unsigned tag;
        tag = 32'(d[24:17]);
        beats_this_req = 0;
        case (op)
            OP_ALLOC: predict_alloc(32'(d[16:0]), tag, d[25], 32'(d[41:26]));
            OP_FREE:
            begin
                s = lookup_offset(32'(d[57:42]));
                if (s == 0)
                    push_beat(KIND_DONE, ST_NOT_ALLOC, 0, 0, 1);
                else
                begin
                    void'(release_slot(s));
                    push_beat(KIND_DONE, ST_OK, 0, 0, 1);
                end
            end
            OP_RANGE:
            begin
                b = blk_next[0];
                steps = 0;
                while (b != 0 && steps < RANGE_LIMIT)
                begin
                    steps++;
                    if ((blk_use[b] == USE_PLAIN || blk_use[b] == USE_OWNED) &&
                        blk_tag[b] >= 32'(d[65:58]) && blk_tag[b] <= 32'(d[73:66]))
                        b = release_slot(b);
                    b = blk_next[b];
                end
                push_beat(KIND_DONE, ST_OK, 0, 0, 1);
            end
            default:
            begin
                s = lookup_offset(32'(d[57:42]));
                if (s == 0)
                    push_beat(KIND_DONE, ST_NOT_ALLOC, 0, 0, 1);
                else if (tag >= purge_level && blk_use[s] != USE_OWNED)
                    push_beat(KIND_DONE, ST_NO_OWNER, 0, 0, 1);
                else
                begin
                    blk_tag[s] = tag;
                    push_beat(KIND_DONE, ST_OK, 0, 0, 1);
                end
            end
        endcase
    endfunction

    // Payload offset of a random live block, or a random offset if none is live.
    function automatic int unsigned live_offset();
        int unsigned hits[$];
        for (int unsigned s = 1; s < MAX_BLOCKS; s++)
            if (blk_taken[s] && (blk_use[s] == USE_PLAIN || blk_use[s] == USE_OWNED))
                hits.push_back((blk_start[s] + HEADER_BYTES) & 16'hFFFF);
        if (hits.size() == 0)
            return $urandom_range(0, 65535);
        return hits[$urandom_range(0, hits.size() - 1)];
    endfunction

    // ---------------------------------------------------------------
    // Clock, reset, watchdog
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Count cycles in which no beat moves; hang means failure.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Predict on every accepted request beat; inputs are stable here since
    // they only change on the falling edge.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_request(op_t'(s_axis_tuser), s_axis_tdata);
            req_accepted++;
        end
    end

    // Compare each accepted result beat with the oldest prediction.
    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_beats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat kind=%0b status=%0d data=%h last=%0b", $time,
                         m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (m_axis_tuser !== want.kind)
                begin
                    errors++;
                    $display("%0t: kind expected %0b actual %0b", $time, want.kind,
                             m_axis_tuser);
                end
                if (m_axis_tdata[2:0] !== want.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             m_axis_tdata[2:0]);
                end
                if (m_axis_tdata[18:3] !== want.offset)
                begin
                    errors++;
                    $display("%0t: result_offset expected %h actual %h", $time, want.offset,
                             m_axis_tdata[18:3]);
                end
                if (m_axis_tdata[34:19] !== want.owner)
                begin
                    errors++;
                    $display("%0t: cleared_owner expected %h actual %h", $time, want.owner,
                             m_axis_tdata[34:19]);
                end
                if (m_axis_tlast !== want.last)
                begin
                    errors++;
                    $display("%0t: last expected %0b actual %0b", $time, want.last,
                             m_axis_tlast);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random stalls, one long hold-off on request
    // ---------------------------------------------------------------
    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                // hold ready low long enough for the block to back up its input
                m_axis_tready = 1'b0;
                repeat (400) @(negedge clk);
                hold_off_req = 1'b0;
                m_axis_tready = 1'b1;
            end
            else
            begin
                n = gap_len();
                if (n == 0)
                    m_axis_tready = 1'b1;
                else
                begin
                    m_axis_tready = 1'b0;
                    repeat (n - 1) @(negedge clk);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    // Drive one request beat and hold it until the block takes it.
    // Called and returns on a falling edge.
    task automatic send_req(op_t op, int unsigned req, int unsigned tag, int unsigned has_own,
                            int unsigned own, int unsigned off, int unsigned lo,
                            int unsigned hi);
        int seen;
        repeat (gap_len()) @(negedge clk);
        s_axis_tuser  = op;
        s_axis_tdata  = {6'b0, hi[7:0], lo[7:0], off[15:0], own[15:0], has_own[0],
                         tag[7:0], req[16:0]};
        s_axis_tvalid = 1'b1;
        seen = req_accepted;
        do
            @(negedge clk);
        while (req_accepted == seen);
        s_axis_tvalid = 1'b0;
        // scramble the idle bus so stale fields never look meaningful
        s_axis_tdata  = 80'({$urandom, $urandom, $urandom});
        s_axis_tuser  = 2'($urandom_range(0, 3));
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0)
            @(negedge clk);
    endtask

    // Write purge_level_tag only with nothing in flight.
    task automatic set_purge_level(int unsigned lvl);
        wait_drained();
        repeat (DRAIN_WAIT / 20) @(negedge clk);
        cfg_wdata = lvl[7:0];
        cfg_wen   = 1'b1;
        @(negedge clk);
        cfg_wen   = 1'b0;
        purge_level = lvl;
    endtask

    task automatic send_random(int unsigned lvl);
        int          r;
        int unsigned sz;
        int unsigned tag;
        int unsigned lo;
        int unsigned hi;
        r = $urandom_range(0, 99);
        tag = ($urandom_range(0, 1) && lvl > 0) ? $urandom_range(0, lvl - 1)
                                                : $urandom_range(lvl, 255);
        if (r < 45)
        begin
            // mostly small sizes so the slot table fills; a few spread up to the largest request
            sz = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 131071)
                                              : $urandom_range(0, 3000);
            send_req(OP_ALLOC, sz, tag, ($urandom_range(0, 9) < 7) ? 1 : 0,
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 255), $urandom_range(0, 255));
        end
        else if (r < 70)
            send_req(OP_FREE, $urandom, $urandom, $urandom, $urandom,
                     ($urandom_range(0, 4) != 0) ? live_offset() : $urandom_range(0, 65535),
                     $urandom, $urandom);
        else if (r < 80)
        begin
            lo = $urandom_range(0, 255);
            hi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(lo, 255);
            send_req(OP_RANGE, $urandom, $urandom, $urandom, $urandom, $urandom, lo, hi);
        end
        else
            send_req(OP_RETAG, $urandom, tag, $urandom, $urandom,
                     ($urandom_range(0, 5) != 0) ? live_offset() : $urandom_range(0, 65535),
                     $urandom, $urandom);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        int unsigned a;
        int unsigned b;
        calm = 1'b1;
        send_req(OP_ALLOC, 131071, 0, 0, 0, 0, 0, 0);          // far too large
        send_req(OP_ALLOC, 65536, 5, 0, 0, 0, 0, 0);           // header pushes it over
        send_req(OP_ALLOC, 100, 200, 0, 0, 0, 0, 0);           // owner missing
        send_req(OP_ALLOC, 0, 255, 1, 'hFFFF, 0, 0, 0);
        send_req(OP_ALLOC, 1, 0, 0, 0, 0, 0, 0);
        send_req(OP_ALLOC, 37, 99, 0, 0, 0, 0, 0);
        send_req(OP_ALLOC, 200, 100, 1, 'h1234, 0, 0, 0);
        wait_drained();
        a = live_offset();
        send_req(OP_RETAG, 0, 150, 0, 0, 24 + 28, 0, 0);       // offset is no block's payload
        send_req(OP_RETAG, 0, 7, 0, 0, 24, 0, 0);              // owned block lowered
        send_req(OP_FREE, 0, 0, 0, 0, 'hFFFF, 0, 0);           // unknown offset
        send_req(OP_RETAG, 0, 3, 0, 0, 'h0001, 0, 0);          // unknown offset
        send_req(OP_RANGE, 0, 0, 0, 0, 0, 200, 100);           // empty range
        send_req(OP_FREE, 0, 0, 0, 0, a, 0, 0);
        send_req(OP_FREE, 0, 0, 0, 0, a, 0, 0);                // second free of same block
        send_req(OP_ALLOC, 2000, 120, 1, 'h00AA, 0, 0, 0);
        send_req(OP_ALLOC, 500, 130, 1, 'h5555, 0, 0, 0);
        wait_drained();
        b = live_offset();
        send_req(OP_RETAG, 0, 255, 0, 0, b, 0, 0);
        send_req(OP_RANGE, 0, 0, 0, 0, 0, 0, 255);             // release everything
        send_req(OP_ALLOC, 65536 - 24, 0, 0, 0, 0, 0, 0);      // exact fit of the arena
        send_req(OP_RANGE, 0, 0, 0, 0, 0, 0, 0);
        calm = 1'b0;
    endtask

    // Lowered level: plain blocks become purgeable without notification.
    task automatic test_purge_levels();
        set_purge_level(0);
        repeat (10) send_random(0);
        set_purge_level(255);
        repeat (20) send_random(255);
        set_purge_level(40);
        repeat (20) send_random(40);
    endtask

    task automatic test_random_default();
        set_purge_level(RESET_PURGE_LEVEL);
        calm = 1'b1;
        repeat (10) send_random(RESET_PURGE_LEVEL);
        calm = 1'b0;
        repeat (30) send_random(RESET_PURGE_LEVEL);
    endtask

    // Receiver stalls long while the sender keeps offering requests.
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        repeat (12) send_random(purge_level);
        wait_drained();
        repeat (8) send_random(purge_level);
    endtask

    initial
    begin
        errors        = 0;
        req_accepted  = 0;
        idle_cycles   = 0;
        hold_off_req  = 1'b0;
        calm          = 1'b0;
        rst_n         = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = 8'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 80'd0;
        s_axis_tuser  = OP_ALLOC;
        shadow_reset();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_default();
        test_backpressure();
        test_purge_levels();

        wait_drained();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
